@@ sv/ipc_pkg.sv @@
// Package for the issue-port contention checker.
// Holds the operation and port-class codes, the group limits and the counter struct.
// No dependencies.
`default_nettype none

package ipc_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_TRY    = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [3:0] CLS_P0    = 4'd0;
    localparam logic [3:0] CLS_P1    = 4'd1;
    localparam logic [3:0] CLS_P5    = 4'd2;
    localparam logic [3:0] CLS_P6    = 4'd3;
    localparam logic [3:0] CLS_P0156 = 4'd4;
    localparam logic [3:0] CLS_P015  = 4'd5;
    localparam logic [3:0] CLS_P01   = 4'd6;
    localparam logic [3:0] CLS_P23   = 4'd7;
    localparam logic [3:0] CLS_P4879 = 4'd8;

    localparam logic [2:0] LIM_0156  = 3'd4;
    localparam logic [1:0] LIM_015   = 2'd3;
    localparam logic [1:0] LIM_01    = 2'd2;
    localparam logic [1:0] LIM_LOAD  = 2'd2;
    localparam logic [1:0] LIM_STORE = 2'd2;

    typedef struct packed {
        logic [3:0] taken;
        logic [2:0] any0156;
        logic [1:0] any015;
        logic [1:0] any01;
        logic [1:0] load;
        logic [1:0] store;
    } port_cnt_t;

endpackage

`default_nettype wire

@@ sv/ipc_port_check.sv @@
// Port-group check for one try-issue item: decides the grant and the bumped counters.
// Purely combinational; depends on ipc_pkg.
`default_nettype none

module ipc_port_check
    import ipc_pkg::*;
(
    input  wire logic [3:0] port_class,
    input  wire port_cnt_t  cnt,
    output logic            grant,
    output port_cnt_t       cnt_next
);

    logic [1:0] port_sel;
    logic       uses_015;
    logic       uses_01;

    assign port_sel = port_class[1:0];
    assign uses_015 = (port_class != CLS_P6);
    assign uses_01  = (port_class != CLS_P5) && (port_class != CLS_P6);

    always_comb
    begin
        cnt_next = cnt;
        grant    = 1'b0;
        unique case (port_class) inside
            CLS_P0156:
            begin
                if (cnt.any0156 < LIM_0156)
                begin
                    grant            = 1'b1;
                    cnt_next.any0156 = cnt.any0156 + 3'd1;
                end
            end
            CLS_P015:
            begin
                if (cnt.any015 < LIM_015)
                begin
                    grant           = 1'b1;
                    cnt_next.any015 = cnt.any015 + 2'd1;
                end
            end
            CLS_P01:
            begin
                if (cnt.any01 < LIM_01)
                begin
                    grant          = 1'b1;
                    cnt_next.any01 = cnt.any01 + 2'd1;
                end
            end
            CLS_P23:
            begin
                if (cnt.load < LIM_LOAD)
                begin
                    grant         = 1'b1;
                    cnt_next.load = cnt.load + 2'd1;
                end
            end
            CLS_P4879:
            begin
                if (cnt.store < LIM_STORE)
                begin
                    grant          = 1'b1;
                    cnt_next.store = cnt.store + 2'd1;
                end
            end
            CLS_P0, CLS_P1, CLS_P5, CLS_P6:
            begin
                if (!cnt.taken[port_sel] && (cnt.any0156 < LIM_0156)
                    && (!uses_015 || (cnt.any015 < LIM_015))
                    && (!uses_01 || (cnt.any01 < LIM_01)))
                begin
                    grant                    = 1'b1;
                    cnt_next.taken[port_sel] = 1'b1;
                    cnt_next.any0156         = cnt.any0156 + 3'd1;
                    if (uses_015)
                    begin
                        cnt_next.any015 = cnt.any015 + 2'd1;
                    end
                    if (uses_01)
                    begin
                        cnt_next.any01 = cnt.any01 + 2'd1;
                    end
                end
            end
            default:
            begin
                grant = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/issue_port_contention.sv @@
// Issue-port contention checker for an out-of-order core.
// Use: items arrive on the req channel (req_valid/req_ready) with operation,
// time_now, port_class, alu_kind and alu_latency. A start-cycle item loads the
// cycle time and clears the port flags and group counters. A try-issue item
// checks the port groups and the ALU busy-until table. A commit item marks the
// ALU busy until the cycle time plus the latency.
// Each item gives exactly one result on the rsp channel (rsp_valid/rsp_ready)
// with issue_ok and no_more, the latter taken after the item's state update.
// The state is updated at the accepting edge and the result sits in the output
// register from the next cycle on.
// Throughput is one item per cycle while each result is taken at once;
// req_ready stays high while the output register is empty or being taken.
// If the receiver stalls, the result is held and further items are refused
// until it is taken. Reset clears the counters, flags, cycle time and the whole
// busy-until table, and empties the output register.
// Depends on ipc_pkg and ipc_port_check.
`default_nettype none

module issue_port_contention
    import ipc_pkg::*;
#(
    parameter int ALU_KINDS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] time_now,
    input  wire logic [3:0]  port_class,
    input  wire logic [1:0]  alu_kind,
    input  wire logic [7:0]  alu_latency,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic             issue_ok,
    output logic             no_more
);

    localparam int IDX_W = (ALU_KINDS > 1) ? $clog2(ALU_KINDS) : 1;

    port_cnt_t          cnt_reg;
    port_cnt_t          cnt_grant;
    port_cnt_t          cnt_after;
    logic [31:0]        cycle_time_reg;
    logic [31:0]        busy_until_reg [ALU_KINDS];
    logic               rsp_valid_reg;
    logic               issue_ok_reg;
    logic               no_more_reg;
    logic               accept;
    logic               grant;
    logic               alu_valid;
    logic [IDX_W-1:0]   alu_idx;
    logic               alu_busy;
    logic               issue_ok_next;
    logic               no_more_next;

    ipc_port_check u_port_check (
        .port_class (port_class),
        .cnt        (cnt_reg),
        .grant      (grant),
        .cnt_next   (cnt_grant)
    );

    assign accept    = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign alu_valid = (alu_kind != 2'd0) && (32'(alu_kind) < 32'(ALU_KINDS));
    assign alu_idx   = IDX_W'(alu_kind);
    assign alu_busy  = alu_valid && (busy_until_reg[alu_idx] > cycle_time_reg);

    always_comb
    begin
        cnt_after     = cnt_reg;
        issue_ok_next = 1'b0;
        unique case (operation)
            OP_START:
            begin
                cnt_after = '0;
            end
            OP_TRY:
            begin
                cnt_after     = cnt_grant;
                issue_ok_next = grant && !alu_busy;
            end
            default:
            begin
                cnt_after = cnt_reg;
            end
        endcase
        no_more_next = (cnt_after.store >= LIM_STORE) && (cnt_after.load >= LIM_LOAD)
                       && (cnt_after.any0156 >= LIM_0156);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            cycle_time_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < ALU_KINDS; i++)
            begin
                busy_until_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                cnt_reg       <= cnt_after;
                rsp_valid_reg <= 1'b1;
                if (operation == OP_START)
                begin
                    cycle_time_reg <= time_now;
                end
                if ((operation == OP_COMMIT) && alu_valid)
                begin
                    busy_until_reg[alu_idx] <= cycle_time_reg + 32'(alu_latency);
                end
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            issue_ok_reg <= issue_ok_next;
            no_more_reg  <= no_more_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign issue_ok  = issue_ok_reg;
    assign no_more   = no_more_reg;

endmodule

`default_nettype wire
